### src/bad4d_pkg.sv
`timescale 1ns / 1ps

package bad4d_pkg;

  // Default sizes for the top-level parameters.
  localparam int SampleBitsDef = 16;
  localparam int AccDepthDef   = 4096;

  // Fixed field widths.
  localparam int MaxFactor = 16;
  localparam int MaxSize   = 4096;
  localparam int SizeW     = 13;
  localparam int FactorW   = 5;
  localparam int CoordW    = 12;
  localparam int PhaseW    = FactorW;
  localparam int WinW      = 4 * FactorW;
  localparam int AccW      = 32;
  localparam int CntW      = 6;
  localparam int ApbAddrW  = 5;
  localparam int ApbDataW  = 32;

  // Configuration register file.
  typedef struct packed {
    logic [SizeW-1:0]   size_x;
    logic [SizeW-1:0]   size_y;
    logic [SizeW-1:0]   size_z;
    logic [FactorW-1:0] factor_x;
    logic [FactorW-1:0] factor_y;
    logic [FactorW-1:0] factor_z;
    logic [FactorW-1:0] factor_w;
  } cfg_t;

  // Register indexes on the APB port.
  typedef enum logic [2:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_FACTOR_X,
    REG_FACTOR_Y,
    REG_FACTOR_Z,
    REG_FACTOR_W
  } reg_idx_t;

  // Which quotient the shared divider is producing.
  typedef enum logic [2:0] {
    DIV_OX,
    DIV_OY,
    DIV_OZ,
    DIV_CX,
    DIV_CY,
    DIV_CZ,
    DIV_AVG
  } div_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CHECK,
    S_CELL_A,
    S_CELL_B,
    S_RD,
    S_WR,
    S_EMIT,
    S_ADVANCE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     cell_a;
    logic     cell_b;
    logic     ram_rd;
    logic     acc_wr;
    logic     emit;
    logic     advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic in_window;
    logic is_last;
    logic out_full;
  } status_t;

  // A zero extent acts as one, anything above the maximum as the maximum.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeW'(MaxSize)) begin
      r = SizeW'(MaxSize);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // A zero factor acts as one, anything above the maximum as the maximum.
  function automatic logic [FactorW-1:0] eff_factor(input logic [FactorW-1:0] v);
    logic [FactorW-1:0] r;
    if (v == '0) begin
      r = FactorW'(1);
    end else if (32'(v) > MaxFactor) begin
      r = FactorW'(MaxFactor);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### src/bad4d_in_if.sv
`timescale 1ns / 1ps

interface bad4d_in_if import bad4d_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_tensor;

  modport source (output valid, sample, end_of_tensor, input ready);
  modport sink   (input valid, sample, end_of_tensor, output ready);
endinterface

### src/bad4d_out_if.sv
`timescale 1ns / 1ps

interface bad4d_out_if import bad4d_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [CoordW-1:0]             out_x;
  logic [CoordW-1:0]             out_y;
  logic [CoordW-1:0]             out_z;
  logic [CoordW-1:0]             out_w;

  modport source (output valid, average, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, average, out_x, out_y, out_z, out_w, output ready);
endinterface

### src/box_average_downsample_4d.sv
`timescale 1ns / 1ps

// Streaming 4-D box-average downsampler. Requests carry Q4.12 samples in raster
// order with dimension 0 fastest; each sample is summed into the accumulator of
// its output cell, and when the last sample of a window arrives the block
// returns the window mean (truncated toward zero) with the cell coordinates.
// The block works on one request at a time. A request that completes a window
// may also wait for a result still held in the output register. The shared
// bit-serial divider runs six 13-bit divisions to find the output extents and
// the cell position, and a 32-bit division to form the average. A finished
// result waits in an output register while the next request is taken.
// The accumulator store has ACC_DEPTH entries (a power of two) and needs no
// clearing, since the first sample of a window overwrites its entry. Registers
// are written over APB at byte address 4*i and must only be changed while the
// block is idle.
module box_average_downsample_4d import bad4d_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int ACC_DEPTH   = AccDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  bad4d_in_if.sink            in_ch,
  bad4d_out_if.source         out_ch
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  cmd_t     cmd;
  status_t  status;
  logic     in_ready;

  assign reg_idx = reg_idx_t'(paddr[ApbAddrW-1:2]);
  assign pready  = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x   <= SizeW'(1);
      cfg.size_y   <= SizeW'(1);
      cfg.size_z   <= SizeW'(1);
      cfg.factor_x <= FactorW'(1);
      cfg.factor_y <= FactorW'(1);
      cfg.factor_z <= FactorW'(1);
      cfg.factor_w <= FactorW'(1);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SIZE_X:   cfg.size_x   <= pwdata[SizeW-1:0];
        REG_SIZE_Y:   cfg.size_y   <= pwdata[SizeW-1:0];
        REG_SIZE_Z:   cfg.size_z   <= pwdata[SizeW-1:0];
        REG_FACTOR_X: cfg.factor_x <= pwdata[FactorW-1:0];
        REG_FACTOR_Y: cfg.factor_y <= pwdata[FactorW-1:0];
        REG_FACTOR_Z: cfg.factor_z <= pwdata[FactorW-1:0];
        REG_FACTOR_W: cfg.factor_w <= pwdata[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_SIZE_X:   prdata = ApbDataW'(cfg.size_x);
      REG_SIZE_Y:   prdata = ApbDataW'(cfg.size_y);
      REG_SIZE_Z:   prdata = ApbDataW'(cfg.size_z);
      REG_FACTOR_X: prdata = ApbDataW'(cfg.factor_x);
      REG_FACTOR_Y: prdata = ApbDataW'(cfg.factor_y);
      REG_FACTOR_Z: prdata = ApbDataW'(cfg.factor_z);
      REG_FACTOR_W: prdata = ApbDataW'(cfg.factor_w);
      default:      prdata = '0;
    endcase
  end

  assign in_ch.ready = in_ready;

  bad4d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  bad4d_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_DEPTH   (ACC_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_sample (in_ch.sample),
    .in_eot    (in_ch.end_of_tensor),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

endmodule

### src/bad4d_ram.sv
`timescale 1ns / 1ps

module bad4d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bad4d_div.sv
`timescale 1ns / 1ps

module bad4d_div import bad4d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             short_mode,
  input  logic [AccW-1:0]  dividend,
  input  logic [WinW-1:0]  divisor,
  output logic [AccW-1:0]  quotient,
  output logic [WinW-1:0]  remainder,
  output logic             done,
  output logic             busy
);

  logic [AccW-1:0] dvd;
  logic [WinW-1:0] rem;
  logic [WinW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            running;
  logic [WinW:0]   rem_sh;
  logic [WinW:0]   rem_diff;
  logic            fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh   = {rem, dvd[AccW-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    fits     = rem_sh >= {1'b0, dvs};
  end

  // Iteration control. A short division only walks the low SizeW bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= short_mode ? CntW'(SizeW) : CntW'(AccW);
      end else if (running) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the dividend register from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= short_mode ? {dividend[SizeW-1:0], (AccW-SizeW)'(0)} : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      dvd <= {dvd[AccW-2:0], fits};
      rem <= fits ? rem_diff[WinW-1:0] : rem_sh[WinW-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;
  assign busy      = running;

endmodule

### src/bad4d_dp.sv
`timescale 1ns / 1ps

module bad4d_dp import bad4d_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int ACC_DEPTH   = AccDepthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_eot,
  input  cmd_t                          cmd,
  output status_t                       status,
  bad4d_out_if.source                   out_ch
);

  localparam int AW = $clog2(ACC_DEPTH);

  logic [SizeW-1:0]   nx, ny, nz;
  logic [FactorW-1:0] fx, fy, fz, fw;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          eot_q;

  logic [CoordW-1:0]  pos_x, pos_y, pos_z, block_w;
  logic [PhaseW-1:0]  phase_w;

  logic [SizeW-1:0]   ox, oy, oz;
  logic [CoordW-1:0]  cx, cy, cz;
  logic [FactorW-1:0] jx, jy, jz;
  logic [AW-1:0]      cell_idx;

  logic [2*FactorW-1:0] win_a;
  logic [3*FactorW-1:0] win_b;
  logic [WinW-1:0]      win;
  logic [AccW-1:0]      acc;
  logic [AccW-1:0]      acc_new;
  logic [AccW-1:0]      acc_mag;
  logic [AccW-1:0]      avg_full;
  logic [AccW-1:0]      ram_rdata;
  logic                 first;

  logic [AccW-1:0] div_dvd;
  logic [WinW-1:0] div_dvs;
  logic [AccW-1:0] div_quo;
  logic [WinW-1:0] div_rem;
  logic            div_done;
  logic            div_busy;

  logic [CoordW-1:0] px1, py1, pz1;
  logic [PhaseW:0]   ph1;
  logic              wrap_x, wrap_y, wrap_z, wrap_w;

  logic out_valid;

  // Effective configuration.
  always_comb begin
    nx = eff_size(cfg.size_x);
    ny = eff_size(cfg.size_y);
    nz = eff_size(cfg.size_z);
    fx = eff_factor(cfg.factor_x);
    fy = eff_factor(cfg.factor_y);
    fz = eff_factor(cfg.factor_z);
    fw = eff_factor(cfg.factor_w);
  end

  // Latch the request payload.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sample_q <= in_sample;
      eot_q    <= in_eot;
    end
  end

  // Divider operand selection.
  always_comb begin
    acc_mag = acc[AccW-1] ? (~acc + AccW'(1)) : acc;
    case (cmd.div_sel)
      DIV_OX: begin
        div_dvd = AccW'(nx);
        div_dvs = WinW'(fx);
      end
      DIV_OY: begin
        div_dvd = AccW'(ny);
        div_dvs = WinW'(fy);
      end
      DIV_OZ: begin
        div_dvd = AccW'(nz);
        div_dvs = WinW'(fz);
      end
      DIV_CX: begin
        div_dvd = AccW'(pos_x);
        div_dvs = WinW'(fx);
      end
      DIV_CY: begin
        div_dvd = AccW'(pos_y);
        div_dvs = WinW'(fy);
      end
      DIV_CZ: begin
        div_dvd = AccW'(pos_z);
        div_dvs = WinW'(fz);
      end
      DIV_AVG: begin
        div_dvd = acc_mag;
        div_dvs = win;
      end
      default: begin
        div_dvd = '0;
        div_dvs = WinW'(1);
      end
    endcase
  end

  bad4d_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .short_mode (cmd.div_sel != DIV_AVG),
    .dividend   (div_dvd),
    .divisor    (div_dvs),
    .quotient   (div_quo),
    .remainder  (div_rem),
    .done       (div_done),
    .busy       (div_busy)
  );

  // Capture output extents, cell coordinates and window offsets.
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        DIV_OX: ox <= div_quo[SizeW-1:0];
        DIV_OY: oy <= div_quo[SizeW-1:0];
        DIV_OZ: oz <= div_quo[SizeW-1:0];
        DIV_CX: begin
          cx <= div_quo[CoordW-1:0];
          jx <= div_rem[FactorW-1:0];
        end
        DIV_CY: begin
          cy <= div_quo[CoordW-1:0];
          jy <= div_rem[FactorW-1:0];
        end
        DIV_CZ: begin
          cz <= div_quo[CoordW-1:0];
          jz <= div_rem[FactorW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Cell index in two multiply-add steps; window size in three small products.
  always_ff @(posedge clk) begin
    if (cmd.cell_a) begin
      cell_idx <= AW'(32'(cz) * 32'(oy) + 32'(cy));
      win_a    <= (2*FactorW)'(fx) * (2*FactorW)'(fy);
    end
    if (cmd.cell_b) begin
      cell_idx <= AW'(32'(cell_idx) * 32'(ox) + 32'(cx));
      win_b    <= (3*FactorW)'(win_a) * (3*FactorW)'(fz);
    end
    if (cmd.ram_rd) begin
      win <= WinW'(win_b) * WinW'(fw);
    end
  end

  // Window membership and first/last contributor flags.
  always_comb begin
    first = (jx == '0) && (jy == '0) && (jz == '0) && (phase_w == '0);
    status.in_window = ({1'b0, cx} < ox) && ({1'b0, cy} < oy) && ({1'b0, cz} < oz)
                       && (phase_w < fw);
    status.is_last = (jx == fx - FactorW'(1)) && (jy == fy - FactorW'(1))
                     && (jz == fz - FactorW'(1)) && (phase_w == fw - FactorW'(1));
    status.div_done = div_done;
    status.div_busy = div_busy;
    status.out_full = out_valid;
  end

  // Accumulate: the first contributor overwrites the stored sum.
  assign acc_new = (first ? '0 : ram_rdata) + AccW'(sample_q);

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      acc <= acc_new;
    end
  end

  bad4d_ram #(
    .WIDTH (AccW),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (cell_idx),
    .wdata (acc_new),
    .re    (cmd.ram_rd),
    .raddr (cell_idx),
    .rdata (ram_rdata)
  );

  // Signed average from the unsigned quotient.
  assign avg_full = acc[AccW-1] ? (~div_quo + AccW'(1)) : div_quo;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.average <= SAMPLE_BITS'(avg_full);
      out_ch.out_x   <= cx;
      out_ch.out_y   <= cy;
      out_ch.out_z   <= cz;
      out_ch.out_w   <= block_w;
    end
  end

  assign out_ch.valid = out_valid;

  // Raster position advance.
  always_comb begin
    px1    = pos_x + CoordW'(1);
    py1    = pos_y + CoordW'(1);
    pz1    = pos_z + CoordW'(1);
    ph1    = {1'b0, phase_w} + (PhaseW+1)'(1);
    wrap_x = (px1 == '0) || ({1'b0, px1} >= nx);
    wrap_y = (py1 == '0) || ({1'b0, py1} >= ny);
    wrap_z = (pz1 == '0) || ({1'b0, pz1} >= nz);
    wrap_w = ph1 >= {1'b0, fw};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      pos_z   <= '0;
      phase_w <= '0;
      block_w <= '0;
    end else if (cmd.advance) begin
      if (eot_q) begin
        pos_x   <= '0;
        pos_y   <= '0;
        pos_z   <= '0;
        phase_w <= '0;
        block_w <= '0;
      end else if (!wrap_x) begin
        pos_x <= px1;
      end else begin
        pos_x <= '0;
        if (!wrap_y) begin
          pos_y <= py1;
        end else begin
          pos_y <= '0;
          if (!wrap_z) begin
            pos_z <= pz1;
          end else begin
            pos_z <= '0;
            if (!wrap_w) begin
              phase_w <= ph1[PhaseW-1:0];
            end else begin
              phase_w <= '0;
              block_w <= block_w + CoordW'(1);
            end
          end
        end
      end
    end
  end

endmodule

### src/bad4d_ctrl.sv
`timescale 1ns / 1ps

module bad4d_ctrl import bad4d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t   state, state_next;
  div_sel_t div_sel, div_sel_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_sel <= DIV_OX;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
    end
  end

  // Next state.
  always_comb begin
    state_next   = state;
    div_sel_next = div_sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next   = S_DIV_GO;
          div_sel_next = DIV_OX;
        end
      end
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          case (div_sel)
            DIV_OX: begin
              div_sel_next = DIV_OY;
              state_next   = S_DIV_GO;
            end
            DIV_OY: begin
              div_sel_next = DIV_OZ;
              state_next   = S_DIV_GO;
            end
            DIV_OZ: begin
              div_sel_next = DIV_CX;
              state_next   = S_DIV_GO;
            end
            DIV_CX: begin
              div_sel_next = DIV_CY;
              state_next   = S_DIV_GO;
            end
            DIV_CY: begin
              div_sel_next = DIV_CZ;
              state_next   = S_DIV_GO;
            end
            DIV_CZ:  state_next = S_CHECK;
            DIV_AVG: state_next = S_EMIT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK:  state_next = status.in_window ? S_CELL_A : S_ADVANCE;
      S_CELL_A: state_next = S_CELL_B;
      S_CELL_B: state_next = S_RD;
      S_RD:     state_next = S_WR;
      S_WR: begin
        if (status.is_last) begin
          state_next   = S_DIV_GO;
          div_sel_next = DIV_AVG;
        end else begin
          state_next = S_ADVANCE;
        end
      end
      S_EMIT: begin
        if (!status.out_full) begin
          state_next = S_ADVANCE;
        end
      end
      S_ADVANCE: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    cmd.div_sel = div_sel;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_DIV_GO:  cmd.div_start = 1'b1;
      S_CELL_A:  cmd.cell_a    = 1'b1;
      S_CELL_B:  cmd.cell_b    = 1'b1;
      S_RD:      cmd.ram_rd    = 1'b1;
      S_WR:      cmd.acc_wr    = 1'b1;
      S_EMIT:    cmd.emit      = !status.out_full;
      S_ADVANCE: cmd.advance   = 1'b1;
      default: ;
    endcase
  end

  // The output register is never overwritten while it still holds a result.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_full)
    else $error("result loaded over a pending result");

  // The divider is only started when idle.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // An accepted request starts with the first extent division.
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIV_GO && div_sel == DIV_OX))
    else $error("request not followed by division sequence");

  // Closing a window always leads to the average division.
  a_last_avg: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && status.is_last) |=> (state == S_DIV_GO && div_sel == DIV_AVG))
    else $error("completed window did not start averaging");

endmodule

### tb/bad4d_checker.sv
`timescale 1ns / 1ps

module bad4d_checker import bad4d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  bad4d_in_if                 in_ch,
  bad4d_out_if                out_ch,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [15:0]       average;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] w;
  } cell_mean_t;

  localparam int Depth = 4096;

  // Shadow of the register file and of the stream position.
  logic [SizeW-1:0]   sz_x, sz_y, sz_z;
  logic [FactorW-1:0] fa_x, fa_y, fa_z, fa_w;
  int unsigned        px, py, pz, ph_w, blk_w;
  logic [31:0]        sums [Depth];
  cell_mean_t         means_q [$];

  function automatic int unsigned extent(input logic [SizeW-1:0] v);
    if (v == 0) return 1;
    return (v > 4096) ? 4096 : int'(v);
  endfunction

  function automatic int unsigned step_of(input logic [FactorW-1:0] v);
    if (v == 0) return 1;
    return (v > 16) ? 16 : int'(v);
  endfunction

  // Sum one sample into its cell and queue the mean when its window closes.
  task automatic accumulate_sample(input logic [15:0] smp, input logic eot);
    int unsigned nx, ny, nz, fx, fy, fz, fw, ox, oy, oz, cx, cy, cz, idx;
    logic        is_first, is_last;
    logic [31:0] acc;
    longint      win;
    longint      mean;
    cell_mean_t  m;
    nx = extent(sz_x);
    ny = extent(sz_y);
    nz = extent(sz_z);
    fx = step_of(fa_x);
    fy = step_of(fa_y);
    fz = step_of(fa_z);
    fw = step_of(fa_w);
    ox = nx / fx;
    oy = ny / fy;
    oz = nz / fz;
    cx = px / fx;
    cy = py / fy;
    cz = pz / fz;
    if (cx < ox && cy < oy && cz < oz && ph_w < fw) begin
      idx = int'((longint'(cz) * oy + cy) * ox + cx) % Depth;
      is_first = (px % fx == 0) && (py % fy == 0) && (pz % fz == 0) && (ph_w == 0);
      is_last = (px % fx == fx - 1) && (py % fy == fy - 1) && (pz % fz == fz - 1)
                && (ph_w == fw - 1);
      acc = is_first ? 32'd0 : sums[idx];
      acc = acc + {{16{smp[15]}}, smp};
      sums[idx] = acc;
      if (is_last) begin
        win = longint'(fx) * fy * fz * fw;
        mean = longint'($signed(acc)) / win;
        m.average = mean[15:0];
        m.x = cx[CoordW-1:0];
        m.y = cy[CoordW-1:0];
        m.z = cz[CoordW-1:0];
        m.w = blk_w[CoordW-1:0];
        means_q.push_back(m);
      end
    end
    // Advance the raster position.
    if (eot) begin
      px = 0;
      py = 0;
      pz = 0;
      ph_w = 0;
      blk_w = 0;
    end else begin
      px = (px + 1) & 12'hFFF;
      if (px == 0 || px >= nx) begin
        px = 0;
        py = (py + 1) & 12'hFFF;
        if (py == 0 || py >= ny) begin
          py = 0;
          pz = (pz + 1) & 12'hFFF;
          if (pz == 0 || pz >= nz) begin
            pz = 0;
            ph_w++;
            if (ph_w >= fw) begin
              ph_w = 0;
              blk_w = (blk_w + 1) & 12'hFFF;
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cell_mean_t got, want;
    if (rst) begin
      sz_x <= 1;
      sz_y <= 1;
      sz_z <= 1;
      fa_x <= 1;
      fa_y <= 1;
      fa_z <= 1;
      fa_w <= 1;
      px = 0;
      py = 0;
      pz = 0;
      ph_w = 0;
      blk_w = 0;
      errors <= 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_SIZE_X:   sz_x <= pwdata[SizeW-1:0];
          REG_SIZE_Y:   sz_y <= pwdata[SizeW-1:0];
          REG_SIZE_Z:   sz_z <= pwdata[SizeW-1:0];
          REG_FACTOR_X: fa_x <= pwdata[FactorW-1:0];
          REG_FACTOR_Y: fa_y <= pwdata[FactorW-1:0];
          REG_FACTOR_Z: fa_z <= pwdata[FactorW-1:0];
          REG_FACTOR_W: fa_w <= pwdata[FactorW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        accumulate_sample(in_ch.sample, in_ch.end_of_tensor);
      end
      // Compare each returned mean with the oldest one predicted.
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.average, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w};
        if (means_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = means_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected avg=%0d x=%0d y=%0d z=%0d w=%0d",
                     $time, $signed(want.average), want.x, want.y, want.z, want.w);
            $display("%0t:          actual   avg=%0d x=%0d y=%0d z=%0d w=%0d",
                     $time, $signed(got.average), got.x, got.y, got.z, got.w);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= means_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bad4d_pkg::*;

  localparam int TotalItems = 1700;
  localparam int WatchLimit = 20000;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int                  errors, pending;
  int                  sent;
  int                  snd_idle, rcv_idle;
  logic                hold_off;
  int                  quiet;

  bad4d_in_if  in_ch ();
  bad4d_out_if out_ch ();

  box_average_downsample_4d dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  bad4d_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch),
    .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WatchLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [ApbDataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One request on the sample channel; gaps come before it at random.
  task automatic send_sample(input logic [15:0] smp, input logic eot);
    if (sent == TotalItems / 3) begin
      snd_idle = 74;
      rcv_idle = 14;
    end else if (sent == 2 * TotalItems / 3) begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.end_of_tensor <= eot;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // Wait until every predicted mean is back and the block has gone quiet.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [ApbDataW-1:0] pick_size();
    case ($urandom_range(11))
      0: return 0;
      1: return 13'h1FFF;
      2: return 4096;
      3: return $urandom_range(8191);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [ApbDataW-1:0] pick_factor();
    case ($urandom_range(11))
      0: return 0;
      1: return 31;
      2: return 16;
      3: return $urandom_range(31);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.end_of_tensor <= 1'b0;
    hold_off = 1'b0;
    quiet = 0;
    sent = 0;
    snd_idle = 14;
    rcv_idle = 74;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x2x2 windows, full-scale positive, full-scale negative,
    // and a small negative sum that must truncate toward zero.
    write_reg(REG_SIZE_X, 2);
    write_reg(REG_SIZE_Y, 2);
    write_reg(REG_SIZE_Z, 2);
    write_reg(REG_FACTOR_X, 2);
    write_reg(REG_FACTOR_Y, 2);
    write_reg(REG_FACTOR_Z, 2);
    write_reg(REG_FACTOR_W, 1);
    for (int i = 0; i < 8; i++) send_sample(16'h7FFF, 1'b0);
    for (int i = 0; i < 8; i++) send_sample(16'h8000, 1'b0);
    for (int i = 0; i < 8; i++) send_sample((i == 3) ? -16'sd7 : 16'd0, i == 7);
    drain();

    // Random phases; each one ends on an end-of-tensor request so the
    // next configuration starts from position zero.
    phase = 0;
    while (sent < TotalItems) begin
      write_reg(REG_SIZE_X, pick_size());
      write_reg(REG_SIZE_Y, pick_size());
      write_reg(REG_SIZE_Z, pick_size());
      write_reg(REG_FACTOR_X, pick_factor());
      write_reg(REG_FACTOR_Y, pick_factor());
      write_reg(REG_FACTOR_Z, pick_factor());
      write_reg(REG_FACTOR_W, pick_factor());
      if (phase == 1) begin
        write_reg(reg_idx_t'(7), $urandom);
      end
      if (phase == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      n = $urandom_range(20, 120);
      for (int i = 0; i < n; i++) begin
        send_sample(pick_sample(), (i == n - 1) || ($urandom_range(59) == 0));
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
